// ===== design/ipsv_pkg.sv =====
package ipsv_pkg;

  // Character classes handed from the front end to the back end
  typedef enum logic [2:0] {
    CLS_DOT,
    CLS_COLON,
    CLS_DIGIT,
    CLS_HEX,
    CLS_OTHER
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [3:0] digit;
    logic       is_final;
  } item_t;

  localparam logic [1:0] VERDICT_NONE = 2'd0;
  localparam logic [1:0] VERDICT_V4   = 2'd1;
  localparam logic [1:0] VERDICT_V6   = 2'd2;

  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;

  localparam logic [8:0] VALUE_CAP  = 9'd256;
  localparam logic [2:0] LEN_CAP    = 3'd7;
  localparam logic [2:0] V4_MAX_LEN = 3'd3;
  localparam logic [2:0] V6_MAX_LEN = 3'd4;
  localparam logic [3:0] V4_GROUPS  = 4'd4;
  localparam logic [3:0] V6_GROUPS  = 4'd8;
  localparam logic [3:0] SEEN_CAP   = 4'd15;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

// ===== design/ip_address_string_validator.sv =====
// Path: a final character is stored in the queue, popped by the back end and graded
// into the registered verdict; a stalled verdict can hold it in the queue.
// Throughput: one character per cycle while verdicts are taken; the back end
// state update (one character per cycle) sets the rate.
// Reset: synchronous, active high; clears the queue, the string state and the
// verdict valid. No clearing pass, requests are taken the cycle after reset.
module ip_address_string_validator (
  input  logic       clk,
  input  logic       rst,
  // character request channel
  input  logic       char_valid,
  output logic       char_stall,
  input  logic [7:0] char_code,
  input  logic       is_final,
  // verdict channel
  output logic       verdict_valid,
  input  logic       verdict_stall,
  output logic [1:0] verdict
);

  logic            push;
  logic            pop;
  logic            full;
  logic            not_empty;
  ipsv_pkg::item_t push_item;
  ipsv_pkg::item_t head;

  // Front end: classify each byte and hand it to the queue; stall only when full
  ipsv_front u_front (
    .char_valid (char_valid),
    .char_code  (char_code),
    .is_final   (is_final),
    .full       (full),
    .char_stall (char_stall),
    .push       (push),
    .item       (push_item)
  );

  // Short queue decouples the front end from a stalled verdict
  ipsv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  // Back end: advance the string state and register the verdict
  ipsv_back u_back (
    .clk           (clk),
    .rst           (rst),
    .not_empty     (not_empty),
    .head          (head),
    .pop           (pop),
    .verdict_valid (verdict_valid),
    .verdict_stall (verdict_stall),
    .verdict       (verdict)
  );

endmodule

// ===== design/ipsv_front.sv =====
module ipsv_front (
  input  logic                char_valid,
  input  logic [7:0]          char_code,
  input  logic                is_final,
  input  logic                full,
  output logic                char_stall,
  output logic                push,
  output ipsv_pkg::item_t     item
);

  logic [7:0] diff;

  assign diff       = char_code - ipsv_pkg::CHAR_ZERO;
  assign char_stall = full;
  assign push       = char_valid && !full;

  // Classify the byte
  always_comb begin
    item.is_final = is_final;
    item.digit    = diff[3:0];
    if (char_code == ipsv_pkg::CHAR_DOT) begin
      item.cls = ipsv_pkg::CLS_DOT;
    end else if (char_code == ipsv_pkg::CHAR_COLON) begin
      item.cls = ipsv_pkg::CLS_COLON;
    end else if (char_code >= ipsv_pkg::CHAR_ZERO && char_code <= ipsv_pkg::CHAR_NINE) begin
      item.cls = ipsv_pkg::CLS_DIGIT;
    end else if ((char_code >= ipsv_pkg::CHAR_LA && char_code <= ipsv_pkg::CHAR_LF) ||
                 (char_code >= ipsv_pkg::CHAR_UA && char_code <= ipsv_pkg::CHAR_UF)) begin
      item.cls = ipsv_pkg::CLS_HEX;
    end else begin
      item.cls = ipsv_pkg::CLS_OTHER;
    end
  end

endmodule

// ===== design/ipsv_queue.sv =====
module ipsv_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ipsv_pkg::item_t push_item,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output ipsv_pkg::item_t head
);

  ipsv_pkg::item_t mem [ipsv_pkg::QUEUE_DEPTH];
  logic [ipsv_pkg::QPTR_W-1:0] wr_ptr;
  logic [ipsv_pkg::QPTR_W-1:0] rd_ptr;
  logic [ipsv_pkg::QCNT_W-1:0] count;

  assign full      = (count == ipsv_pkg::QCNT_W'(ipsv_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == ipsv_pkg::QPTR_W'(ipsv_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == ipsv_pkg::QPTR_W'(ipsv_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/ipsv_back.sv =====
module ipsv_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            not_empty,
  input  ipsv_pkg::item_t head,
  output logic            pop,
  output logic            verdict_valid,
  input  logic            verdict_stall,
  output logic [1:0]      verdict
);

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_V4,
    MODE_V6
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [2:0] glen;
    logic [8:0] gval;
    logic       fz;
    logic [3:0] gseen;
    logic       failed;
  } st_t;

  st_t        st;
  st_t        st_next;
  st_t        s;
  st_t        fin;
  logic [1:0] verdict_next;
  logic [11:0] prod;

  // Check the open group against the mode, count it and clear it
  function automatic st_t close_grp(st_t g);
    st_t  r;
    logic ok;
    r = g;
    unique case (g.mode)
      MODE_V4: ok = (g.glen >= 3'd1) && (g.glen <= ipsv_pkg::V4_MAX_LEN) &&
                    (g.gval < ipsv_pkg::VALUE_CAP) && !(g.fz && g.glen > 3'd1);
      MODE_V6: ok = (g.glen >= 3'd1) && (g.glen <= ipsv_pkg::V6_MAX_LEN);
      default: ok = 1'b0;
    endcase
    r.failed = g.failed | ~ok;
    if (g.gseen != ipsv_pkg::SEEN_CAP) begin
      r.gseen = g.gseen + 4'd1;
    end
    r.glen = '0;
    r.gval = '0;
    r.fz   = 1'b0;
    return r;
  endfunction

  assign pop  = not_empty && (!verdict_valid || !verdict_stall);
  assign prod = 12'(st.gval) * 12'd10 + 12'(head.digit);

  always_comb begin
    mode_t want;
    s    = st;
    want = (head.cls == ipsv_pkg::CLS_DOT) ? MODE_V4 : MODE_V6;
    if (!st.failed) begin
      case (head.cls) inside
        ipsv_pkg::CLS_DOT, ipsv_pkg::CLS_COLON: begin
          if (st.mode != MODE_NONE && st.mode != want) begin
            s.failed = 1'b1;
          end else begin
            s.mode = want;
            s = close_grp(s);
            if (s.gseen >= ((want == MODE_V4) ? ipsv_pkg::V4_GROUPS : ipsv_pkg::V6_GROUPS)) begin
              s.failed = 1'b1;
            end
          end
        end
        ipsv_pkg::CLS_DIGIT: begin
          if (st.glen == 3'd0 && head.digit == 4'd0) begin
            s.fz = 1'b1;
          end
          if (st.gval < ipsv_pkg::VALUE_CAP) begin
            s.gval = (prod > 12'(ipsv_pkg::VALUE_CAP)) ? ipsv_pkg::VALUE_CAP : prod[8:0];
          end
          if (st.glen != ipsv_pkg::LEN_CAP) begin
            s.glen = st.glen + 3'd1;
          end
        end
        ipsv_pkg::CLS_HEX: begin
          if (st.mode == MODE_V4) begin
            s.failed = 1'b1;
          end else begin
            s.gval = ipsv_pkg::VALUE_CAP;
            if (st.glen != ipsv_pkg::LEN_CAP) begin
              s.glen = st.glen + 3'd1;
            end
          end
        end
        default: s.failed = 1'b1;
      endcase
    end

    // Close the last group and grade the string
    fin = s;
    if (!s.failed) begin
      fin = close_grp(s);
    end
    verdict_next = ipsv_pkg::VERDICT_NONE;
    if (!fin.failed) begin
      if (fin.mode == MODE_V4 && fin.gseen == ipsv_pkg::V4_GROUPS) begin
        verdict_next = ipsv_pkg::VERDICT_V4;
      end else if (fin.mode == MODE_V6 && fin.gseen == ipsv_pkg::V6_GROUPS) begin
        verdict_next = ipsv_pkg::VERDICT_V6;
      end
    end

    st_next = head.is_final ? '0 : s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= '0;
      verdict_valid <= 1'b0;
    end else begin
      if (pop) begin
        st <= st_next;
      end
      if (pop && head.is_final) begin
        verdict_valid <= 1'b1;
      end else if (!verdict_stall) begin
        verdict_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.is_final) begin
      verdict <= verdict_next;
    end
  end

endmodule

// ===== design/ipsv_checker.sv =====
module ipsv_checker (
  input logic       clk,
  input logic       rst,
  input logic       char_stall,
  input logic       verdict_valid,
  input logic       verdict_stall,
  input logic [1:0] verdict
);

  // Verdict holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && verdict_stall |=> verdict_valid && $stable(verdict))
    else $error("verdict dropped or changed while stalled");

  // Only defined verdict codes
  a_code: assert property (@(posedge clk) disable iff (rst)
    verdict_valid |-> (verdict == ipsv_pkg::VERDICT_NONE) ||
                      (verdict == ipsv_pkg::VERDICT_V4) ||
                      (verdict == ipsv_pkg::VERDICT_V6))
    else $error("undefined verdict code");

  // Input only backs up behind a stalled verdict
  a_stall: assert property (@(posedge clk) disable iff (rst)
    char_stall |-> $past(verdict_valid && verdict_stall))
    else $error("char stall without a stalled verdict");

  // Reset empties the output
  a_reset: assert property (@(posedge clk)
    rst |=> !verdict_valid && !char_stall)
    else $error("outputs not cleared by reset");

endmodule

bind ip_address_string_validator ipsv_checker u_ipsv_checker (
  .clk           (clk),
  .rst           (rst),
  .char_stall    (char_stall),
  .verdict_valid (verdict_valid),
  .verdict_stall (verdict_stall),
  .verdict       (verdict)
);
